### hdl/fhd_pkg.sv
// ----------------------------------------------------------------------------
// fhd_pkg
// Shared types and constants of the frame header deframer.
// ----------------------------------------------------------------------------
package fhd_pkg;

  // header layout
  localparam int unsigned HDR_LEN = 16;
  localparam logic [3:0]  HDR_LAST = 4'(HDR_LEN - 1);
  localparam logic [31:0] MAGIC = 32'h4C46_5450;
  localparam logic [7:0]  VERSION = 8'd1;

  // configuration register indexes
  localparam logic CFG_MAX_BODY_LEN = 1'b0;
  localparam logic CFG_TYPE_MASK    = 1'b1;

  // configuration reset values
  localparam logic [31:0] MAX_BODY_LEN_RST = 32'd16777216;
  localparam logic [63:0] TYPE_MASK_RST    = 64'd4094;

  // result kind
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_BODY   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  // error codes
  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_BAD_MAGIC   = 3'd1,
    ERR_BAD_VERSION = 3'd2,
    ERR_BAD_TYPE    = 3'd3,
    ERR_TOO_LONG    = 3'd4
  } err_e;

  // deframer phase, one-hot
  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_BODY   = 3'b010,
    PH_ERROR  = 3'b100
  } phase_e;

  // one result beat
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  msg_type;
    logic [15:0] frame_flags;
    logic [31:0] body_length;
    logic [7:0]  body_byte;
    logic        last_of_frame;
    err_e        error_code;
  } result_t;

endpackage

### hdl/fhd_core.sv
// ----------------------------------------------------------------------------
// fhd_core
// Frame state, header store and header checks; produces at most one result
// per processed byte.
// ----------------------------------------------------------------------------
module fhd_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          byte_i,
  input  logic [31:0]         max_body_len_i,
  input  logic [63:0]         valid_type_mask_i,
  output logic                has_result_o,
  output fhd_pkg::result_t    result_o
);

  fhd_pkg::phase_e phase_q, phase_d;
  logic [3:0]      hdr_cnt_q, hdr_cnt_d;
  logic [31:0]     rem_q, rem_d;
  logic [7:0]      store_q [fhd_pkg::HDR_LEN-1];
  logic [7:0]      hdr [fhd_pkg::HDR_LEN];

  logic            last_hdr;
  logic            magic_ok, version_ok, type_ok, len_ok;
  logic [31:0]     len_hi, len_lo;
  logic [15:0]     flags;
  logic [31:0]     left;

  // full header view: stored bytes plus the current one
  always_comb begin
    for (int i = 0; i < fhd_pkg::HDR_LEN - 1; i++) begin
      hdr[i] = store_q[i];
    end
    hdr[fhd_pkg::HDR_LEN-1] = byte_i;
  end

  // header checks
  assign last_hdr   = (hdr_cnt_q == fhd_pkg::HDR_LAST);
  assign magic_ok   = ({hdr[0], hdr[1], hdr[2], hdr[3]} == fhd_pkg::MAGIC);
  assign version_ok = (hdr[4] == fhd_pkg::VERSION);
  assign type_ok    = (hdr[5][7:6] == 2'b00) && valid_type_mask_i[hdr[5][5:0]];
  assign len_hi     = {hdr[8], hdr[9], hdr[10], hdr[11]};
  assign len_lo     = {hdr[12], hdr[13], hdr[14], hdr[15]};
  assign len_ok     = (len_hi == 32'd0) && (len_lo <= max_body_len_i);
  assign flags      = {hdr[6], hdr[7]};

  // body countdown, saturating at zero
  assign left = (rem_q == 32'd0) ? 32'd0 : rem_q - 32'd1;

  // next state and result
  always_comb begin
    phase_d      = phase_q;
    hdr_cnt_d    = hdr_cnt_q;
    rem_d        = rem_q;
    has_result_o = 1'b0;
    result_o     = '{kind: fhd_pkg::KIND_ERROR, msg_type: 8'd0, frame_flags: 16'd0,
                     body_length: 32'd0, body_byte: 8'd0, last_of_frame: 1'b0,
                     error_code: fhd_pkg::ERR_NONE};
    case (phase_q)
      fhd_pkg::PH_HEADER: begin
        hdr_cnt_d = hdr_cnt_q + 4'd1;
        if (last_hdr) begin
          hdr_cnt_d    = 4'd0;
          has_result_o = 1'b1;
          if (!magic_ok) begin
            phase_d             = fhd_pkg::PH_ERROR;
            result_o.error_code = fhd_pkg::ERR_BAD_MAGIC;
          end else if (!version_ok) begin
            phase_d             = fhd_pkg::PH_ERROR;
            result_o.error_code = fhd_pkg::ERR_BAD_VERSION;
          end else if (!type_ok) begin
            phase_d             = fhd_pkg::PH_ERROR;
            result_o.error_code = fhd_pkg::ERR_BAD_TYPE;
          end else if (!len_ok) begin
            phase_d             = fhd_pkg::PH_ERROR;
            result_o.error_code = fhd_pkg::ERR_TOO_LONG;
          end else begin
            rem_d                  = len_lo;
            phase_d                = (len_lo == 32'd0) ? fhd_pkg::PH_HEADER
                                                       : fhd_pkg::PH_BODY;
            result_o.kind          = fhd_pkg::KIND_HEADER;
            result_o.msg_type      = hdr[5];
            result_o.frame_flags   = flags;
            result_o.body_length   = len_lo;
            result_o.last_of_frame = (len_lo == 32'd0);
          end
        end
      end
      fhd_pkg::PH_BODY: begin
        rem_d                  = left;
        has_result_o           = 1'b1;
        result_o.kind          = fhd_pkg::KIND_BODY;
        result_o.body_byte     = byte_i;
        result_o.last_of_frame = (left == 32'd0);
        if (left == 32'd0) begin
          phase_d   = fhd_pkg::PH_HEADER;
          hdr_cnt_d = 4'd0;
        end
      end
      default: begin
        // error phase and unused codes drop the byte
        phase_d = fhd_pkg::PH_ERROR;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= fhd_pkg::PH_HEADER;
      hdr_cnt_q <= 4'd0;
      rem_q     <= 32'd0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      rem_q     <= rem_d;
    end
  end

  // header byte store, last byte is used straight from the input
  always_ff @(posedge clk_i) begin
    if (fire_i && (phase_q == fhd_pkg::PH_HEADER) && !last_hdr) begin
      store_q[hdr_cnt_q] <= byte_i;
    end
  end

endmodule

### hdl/frame_header_deframer.sv
// ----------------------------------------------------------------------------
// frame_header_deframer
// Splits a byte stream into checked 16-byte headers and body bytes.
// ----------------------------------------------------------------------------
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------
//  input    | in_valid_i / in_stall_o | data_byte_i
//  output   | out_valid_o / out_stall_i | kind, msg_type, frame_flags,
//           |                         |   body_length, body_byte,
//           |                         |   last_of_frame, error_code
//  config   | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// One byte per clock sustained while no result beat stalls; a byte's result
// passes from the input register through core logic to the result register.
// Header bytes that give no result move on even while a result is stalled.
// Reset clears frame state and both valid flags and restores the configuration.
// After a failed header check every byte is dropped until reset.
module frame_header_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  msg_type_o,
  output logic [15:0] frame_flags_o,
  output logic [31:0] body_length_o,
  output logic [7:0]  body_byte_o,
  output logic        last_of_frame_o,
  output logic [2:0]  error_code_o
);

  logic [31:0]      max_body_len_q;
  logic [63:0]      type_mask_q;
  logic             in_vld_q;
  logic [7:0]       in_byte_q;
  logic             out_vld_q;
  fhd_pkg::result_t out_q;
  fhd_pkg::result_t core_res;
  logic             core_has_res;
  logic             fire;
  logic             in_accept;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_body_len_q <= fhd_pkg::MAX_BODY_LEN_RST;
      type_mask_q    <= fhd_pkg::TYPE_MASK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fhd_pkg::CFG_MAX_BODY_LEN: max_body_len_q <= cfg_wdata_i[31:0];
        fhd_pkg::CFG_TYPE_MASK:    type_mask_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // a byte is processed unless its result would overwrite a stalled beat
  assign fire       = in_vld_q && (!core_has_res || !out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= data_byte_i;
    end
  end

  fhd_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .fire_i            (fire),
    .byte_i            (in_byte_q),
    .max_body_len_i    (max_body_len_q),
    .valid_type_mask_i (type_mask_q),
    .has_result_o      (core_has_res),
    .result_o          (core_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire && core_has_res) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && core_has_res) begin
      out_q <= core_res;
    end
  end

  // output beat
  assign out_valid_o     = out_vld_q;
  assign kind_o          = out_q.kind;
  assign msg_type_o      = out_q.msg_type;
  assign frame_flags_o   = out_q.frame_flags;
  assign body_length_o   = out_q.body_length;
  assign body_byte_o     = out_q.body_byte;
  assign last_of_frame_o = out_q.last_of_frame;
  assign error_code_o    = out_q.error_code;

endmodule

### tb/sv/frame_header_deframer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_header_deframer_tb
// Streams well-formed frames through the deframer under random sender gaps
// and receiver stalls, predicts every header and body beat in step with the
// accepted bytes and compares each output beat field by field. The run ends
// on one randomly chosen header error followed by bytes that must be dropped.
// ----------------------------------------------------------------------------
module frame_header_deframer_tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = fhd_pkg::CFG_MAX_BODY_LEN;
  logic [63:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  msg_type_o;
  logic [15:0] frame_flags_o;
  logic [31:0] body_length_o;
  logic [7:0]  body_byte_o;
  logic        last_of_frame_o;
  logic [2:0]  error_code_o;

  frame_header_deframer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .msg_type_o      (msg_type_o),
    .frame_flags_o   (frame_flags_o),
    .body_length_o   (body_length_o),
    .body_byte_o     (body_byte_o),
    .last_of_frame_o (last_of_frame_o),
    .error_code_o    (error_code_o)
  );

  always #5 clk_i = ~clk_i;

  // bytes waiting to be sent and beats waiting to be seen
  logic [7:0]       stream_q[$];
  fhd_pkg::result_t pending_results[$];
  int unsigned      queued = 0;
  int unsigned      fail_count = 0;

  // deframer state as predicted
  fhd_pkg::phase_e model_phase = fhd_pkg::PH_HEADER;
  logic [3:0]      hdr_cnt = '0;
  logic [7:0]      hdr_bytes[16];
  logic [31:0]     body_left = '0;
  logic [31:0]     max_len = fhd_pkg::MAX_BODY_LEN_RST;
  logic [63:0]     type_mask = fhd_pkg::TYPE_MASK_RST;

  // long receiver hold-off, requested by the stimulus
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;

  int unsigned      gap_left = 0;
  int unsigned      burst_left = 1;
  fhd_pkg::result_t predicted;
  fhd_pkg::result_t want;

  // one accepted byte through the deframer, returns 1 when a beat is due
  function automatic bit deframe_byte(input logic [7:0] b, output fhd_pkg::result_t r);
    logic [63:0] len;
    logic [7:0]  typ;
    logic [31:0] left;
    r = '0;
    case (model_phase)
      fhd_pkg::PH_HEADER: begin
        hdr_bytes[hdr_cnt] = b;
        if (hdr_cnt != fhd_pkg::HDR_LAST) begin
          hdr_cnt = hdr_cnt + 4'd1;
          return 1'b0;
        end
        hdr_cnt = '0;
        typ = hdr_bytes[5];
        len = '0;
        for (int i = 8; i < 16; i++) len = {len[55:0], hdr_bytes[i]};
        r.kind = fhd_pkg::KIND_ERROR;
        model_phase = fhd_pkg::PH_ERROR;
        // checks in fixed order: magic, version, type, length
        if ({hdr_bytes[0], hdr_bytes[1], hdr_bytes[2], hdr_bytes[3]} != fhd_pkg::MAGIC)
          r.error_code = fhd_pkg::ERR_BAD_MAGIC;
        else if (hdr_bytes[4] != fhd_pkg::VERSION)
          r.error_code = fhd_pkg::ERR_BAD_VERSION;
        else if (typ >= 8'd64 || !type_mask[typ[5:0]])
          r.error_code = fhd_pkg::ERR_BAD_TYPE;
        else if (len > {32'd0, max_len})
          r.error_code = fhd_pkg::ERR_TOO_LONG;
        else begin
          r.kind = fhd_pkg::KIND_HEADER;
          r.msg_type = typ;
          r.frame_flags = {hdr_bytes[6], hdr_bytes[7]};
          r.body_length = len[31:0];
          r.last_of_frame = (len == 0);
          body_left = len[31:0];
          model_phase = (len == 0) ? fhd_pkg::PH_HEADER : fhd_pkg::PH_BODY;
        end
        return 1'b1;
      end
      fhd_pkg::PH_BODY: begin
        left = (body_left == 0) ? 32'd0 : body_left - 32'd1;
        body_left = left;
        if (left == 0) begin
          model_phase = fhd_pkg::PH_HEADER;
          hdr_cnt = '0;
        end
        r.kind = fhd_pkg::KIND_BODY;
        r.body_byte = b;
        r.last_of_frame = (left == 0);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [127:0] make_header(input logic [31:0] magic,
                                               input logic [7:0] ver,
                                               input logic [7:0] typ,
                                               input logic [15:0] flags,
                                               input logic [63:0] len);
    return {magic, ver, typ, flags, len};
  endfunction

  // random type code that the current mask accepts
  function automatic logic [7:0] pick_type();
    logic [7:0] t;
    t = 8'($urandom_range(0, 63));
    while (!type_mask[t[5:0]]) t = 8'($urandom_range(0, 63));
    return t;
  endfunction

  // body length within the limit, often right at the cap
  function automatic int unsigned pick_len();
    int unsigned cap;
    cap = (max_len < 24) ? max_len : 24;
    return ($urandom_range(0, 3) == 0) ? cap : $urandom_range(0, cap);
  endfunction

  task automatic queue_hdr_bytes(input logic [127:0] hdr, input int first, input int last);
    int i;
    for (i = first; i <= last; i++) stream_q.push_back(hdr[127 - 8 * i -: 8]);
    queued += last - first + 1;
  endtask

  task automatic send_body(input int unsigned len);
    repeat (len) stream_q.push_back(8'($urandom));
    queued += len;
  endtask

  task automatic send_frame(input logic [7:0] typ, input logic [15:0] flags,
                            input int unsigned len);
    queue_hdr_bytes(make_header(fhd_pkg::MAGIC, fhd_pkg::VERSION, typ, flags, 64'(len)),
                    0, 15);
    send_body(len);
  endtask

  // sender drained, all beats seen, pipeline given time to settle
  task automatic wait_idle();
    @(negedge clk_i);
    while (stream_q.size() != 0 || in_valid_i || pending_results.size() != 0)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [63:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == fhd_pkg::CFG_MAX_BODY_LEN) max_len = data[31:0];
    else type_mask = data;
  endtask

  // sender: bursts of random length with random gaps, payload held while stalled
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        if (deframe_byte(data_byte_i, predicted)) pending_results.push_back(predicted);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (stream_q.size() != 0) begin
          in_valid_i  <= 1'b1;
          data_byte_i <= stream_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            case ($urandom_range(0, 15))
              0, 1, 2, 3, 4: gap_left <= 0;
              15:            gap_left <= $urandom_range(10, 40);
              default:       gap_left <= $urandom_range(1, 5);
            endcase
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall: long hold-off on request, otherwise a changing pattern
  always @(posedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen   <= hold_req;
      hold_left   <= 400;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(10, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        2:       out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  // result check against the oldest predicted beat
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected beat: kind %0d err %0d", kind_o, error_code_o);
      end else begin
        want = pending_results.pop_front();
        if (kind_o !== want.kind || msg_type_o !== want.msg_type ||
            frame_flags_o !== want.frame_flags || body_length_o !== want.body_length ||
            body_byte_o !== want.body_byte || last_of_frame_o !== want.last_of_frame ||
            error_code_o !== want.error_code) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch exp: kind %0d type %0d flags %h len %0d byte %h last %0d err %0d",
                     want.kind, want.msg_type, want.frame_flags, want.body_length,
                     want.body_byte, want.last_of_frame, want.error_code);
            $display("         got: kind %0d type %0d flags %h len %0d byte %h last %0d err %0d",
                     kind_o, msg_type_o, frame_flags_o, body_length_o,
                     body_byte_o, last_of_frame_o, error_code_o);
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [31:0]  lim;
    logic [63:0]  mask;
    logic [127:0] hdr;
    logic [7:0]   v;
    int unsigned  phase_start;
    int           ph;
    int           k;
    int           err_pick;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset limits: empty frame, then a short body with extreme bytes
    send_frame(8'd1, 16'h0000, 0);
    queue_hdr_bytes(make_header(fhd_pkg::MAGIC, fhd_pkg::VERSION, 8'd11, 16'hFFFF, 64'd3),
                    0, 15);
    stream_q.push_back(8'h00);
    stream_q.push_back(8'hFF);
    stream_q.push_back(8'h5A);
    queued += 3;
    wait_idle();

    // every type allowed, zero length limit, lowest and highest type code
    write_cfg(fhd_pkg::CFG_TYPE_MASK, '1);
    write_cfg(fhd_pkg::CFG_MAX_BODY_LEN, 64'd0);
    send_frame(8'd0, 16'($urandom), 0);
    send_frame(8'd63, 16'($urandom), 0);
    wait_idle();

    // limit raised in the middle of a header, length right at the new limit
    write_cfg(fhd_pkg::CFG_MAX_BODY_LEN, 64'd3);
    hdr = make_header(fhd_pkg::MAGIC, fhd_pkg::VERSION, 8'd2, 16'($urandom), 64'd4);
    queue_hdr_bytes(hdr, 0, 7);
    wait_idle();
    write_cfg(fhd_pkg::CFG_MAX_BODY_LEN, 64'd4);
    queue_hdr_bytes(hdr, 8, 15);
    send_body(4);
    wait_idle();

    // random frames under changing limits and masks
    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0:       lim = '1;
        1:       lim = $urandom_range(0, 6);
        2:       lim = $urandom;
        default: lim = $urandom_range(7, 40);
      endcase
      case (ph % 3)
        0:       mask = '1;
        1:       mask = {$urandom, $urandom} | (64'd1 << $urandom_range(0, 63));
        default: mask = 64'd1 << $urandom_range(0, 63);
      endcase
      wait_idle();
      write_cfg(fhd_pkg::CFG_MAX_BODY_LEN, {32'd0, lim});
      write_cfg(fhd_pkg::CFG_TYPE_MASK, mask);
      if (ph == 4) hold_req++;
      phase_start = queued;
      while (queued - phase_start < 165)
        send_frame(pick_type(), 16'($urandom), pick_len());
    end

    // one failing header ends the stream; later bytes are dropped
    hdr = make_header(fhd_pkg::MAGIC, fhd_pkg::VERSION, pick_type(), 16'($urandom),
                      64'(pick_len()));
    err_pick = $urandom_range(1, 4);
    case (err_pick)
      1: begin
        k = $urandom_range(0, 3);
        hdr[127 - 8 * k -: 8] = hdr[127 - 8 * k -: 8] ^ 8'($urandom_range(1, 255));
      end
      2: begin
        v = 8'($urandom);
        if (v == fhd_pkg::VERSION) v = 8'd0;
        hdr[95:88] = v;
      end
      3: begin
        if (type_mask == '1 || $urandom_range(0, 1) == 0) begin
          hdr[87:80] = 8'($urandom_range(64, 255));
        end else begin
          v = 8'($urandom_range(0, 63));
          while (type_mask[v[5:0]]) v = 8'($urandom_range(0, 63));
          hdr[87:80] = v;
        end
      end
      default: begin
        if (max_len == '1 || $urandom_range(0, 1) == 0)
          hdr[63:0] = {32'($urandom_range(1, 32'hFFFF_FFFF)), 32'($urandom)};
        else
          hdr[63:0] = {32'd0, max_len} + 64'd1 + 64'($urandom_range(0, 1000));
      end
    endcase
    queue_hdr_bytes(hdr, 0, 15);
    send_body(20);

    @(negedge clk_i);
    while (stream_q.size() != 0 || in_valid_i || pending_results.size() != 0)
      @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
